>>> design/assert_macros.svh
// Assertion macros shared by the design files.
// Each macro samples on the rising edge of clock and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CHK_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/hslrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB565 package
// Fraction format, derived widths and the hue sector codes.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

   localparam int FRAC_BITS  = 10;
   localparam int FW         = FRAC_BITS + 1;
   localparam int CW         = 2 * FRAC_BITS + 1;
   localparam int PW         = 2 * FRAC_BITS + 7;
   localparam int NW         = 2 * FRAC_BITS + 8;
   localparam int QW         = 11;
   localparam int SHIFT_5B   = 2 * FRAC_BITS - 2;
   localparam int SHIFT_6B   = 2 * FRAC_BITS - 3;

   localparam logic [FW-1:0] ONE       = FW'(1) << FRAC_BITS;
   localparam logic [8:0]    SECTOR_DEG = 9'd60;
   localparam logic [8:0]    HUE_LIMIT  = 9'd360;
   localparam logic [6:0]    SIXTY      = 7'd60;
   localparam logic [6:0]    ONE_TWENTY = 7'd120;
   localparam logic [11:0]   RECIP_15   = 12'd2185;
   localparam int            RECIP_SH   = 15;
   localparam logic [4:0]    MAX_5B     = 5'd31;
   localparam logic [5:0]    MAX_6B     = 6'd63;

   typedef enum logic [2:0] {
      SECT_RY = 3'd0,
      SECT_YG = 3'd1,
      SECT_GC = 3'd2,
      SECT_CB = 3'd3,
      SECT_BM = 3'd4,
      SECT_MR = 3'd5
   } sector_type;

endpackage

>>> design/hsl_to_rgb565_convert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB565 converter
// Converts one HSL color word per clock into a packed RGB565 pixel while the output is not stalled.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    hue_deg, saturation, lightness
//   rsp_      out        rsp_valid/rsp_ready    pixel_rgb565, hue_error
//
// The pipeline has five register stages; one word enters per cycle while
// req_ready is high. The chroma multiply, the hue-fraction multiply and the
// divide by fifteen each own a stage. Each stage advances when it is empty or
// the next one can take its word, so a stalled output fills the bubbles first.
// Reset clears all stage valid bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsl_to_rgb565_convert_core
   import hslrgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [8:0]  req_hue_deg,
   input  logic [10:0] req_saturation,
   input  logic [10:0] req_lightness,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pixel_rgb565,
   output logic        rsp_hue_error
);

   logic [5:1] vld_ff, vld_in, en;

   // Stage 1
   logic             err1_ff, err1_in;
   sector_type       sec1_ff, sec1_in;
   logic [5:0]       frac1_ff, frac1_in;
   logic [FW-1:0]    sat1_ff, sat1_in, omd1_ff, omd1_in, lit1_ff, lit1_in;
   // Stage 2
   logic             err2_ff;
   sector_type       sec2_ff;
   logic [5:0]       frac2_ff;
   logic [FW-1:0]    lit2_ff;
   logic [CW-1:0]    cn2_ff, cn2_in;
   // Stage 3
   logic             err3_ff;
   sector_type       sec3_ff;
   logic [PW-1:0]    cf3_ff, cf3_in;
   logic [NW-1:0]    cn60_3_ff, cn60_3_in, lm3_ff, lm3_in;
   // Stage 4
   logic             err4_ff;
   logic [QW-1:0]    qr4_ff, qr4_in, qg4_ff, qg4_in, qb4_ff, qb4_in;
   // Stage 5
   logic [15:0]      pix5_ff, pix5_in;
   logic             err5_ff;

   always_comb begin
      en[5] = !vld_ff[5] || rsp_ready;
      en[4] = !vld_ff[4] || en[5];
      en[3] = !vld_ff[3] || en[4];
      en[2] = !vld_ff[2] || en[3];
      en[1] = !vld_ff[1] || en[2];
      vld_in[1] = en[1] ? req_valid : vld_ff[1];
      vld_in[2] = en[2] ? vld_ff[1] : vld_ff[2];
      vld_in[3] = en[3] ? vld_ff[2] : vld_ff[3];
      vld_in[4] = en[4] ? vld_ff[3] : vld_ff[4];
      vld_in[5] = en[5] ? vld_ff[4] : vld_ff[5];
   end

   assign req_ready = en[1];

   // Stage 1: saturate fractions, lightness deviation, hue sector.
   logic [FW:0]   two_l;
   logic [FW-1:0] dev;
   logic [8:0]    rem9;
   logic [5:0]    rem;

   always_comb begin
      sat1_in = (req_saturation > ONE) ? ONE : req_saturation;
      lit1_in = (req_lightness > ONE) ? ONE : req_lightness;
      two_l   = {lit1_in, 1'b0};
      if (two_l >= {1'b0, ONE}) begin
         dev = FW'(two_l - {1'b0, ONE});
      end else begin
         dev = FW'({1'b0, ONE} - two_l);
      end
      omd1_in = ONE - dev;
      err1_in = (req_hue_deg >= HUE_LIMIT);
      if (req_hue_deg < SECTOR_DEG) begin
         sec1_in = SECT_RY;
         rem9    = req_hue_deg;
      end else if (req_hue_deg < 9'(2 * SECTOR_DEG)) begin
         sec1_in = SECT_YG;
         rem9    = req_hue_deg - SECTOR_DEG;
      end else if (req_hue_deg < 9'(3 * SECTOR_DEG)) begin
         sec1_in = SECT_GC;
         rem9    = req_hue_deg - 9'(2 * SECTOR_DEG);
      end else if (req_hue_deg < 9'(4 * SECTOR_DEG)) begin
         sec1_in = SECT_CB;
         rem9    = req_hue_deg - 9'(3 * SECTOR_DEG);
      end else if (req_hue_deg < 9'(5 * SECTOR_DEG)) begin
         sec1_in = SECT_BM;
         rem9    = req_hue_deg - 9'(4 * SECTOR_DEG);
      end else begin
         sec1_in = SECT_MR;
         rem9    = req_hue_deg - 9'(5 * SECTOR_DEG);
      end
      rem      = rem9[5:0];
      frac1_in = sec1_in[0] ? (SIXTY[5:0] - rem) : rem;
   end

   // Stage 2: chroma numerator.
   assign cn2_in = CW'(omd1_ff * sat1_ff);

   // Stage 3: hue-fraction product, half chroma and lightness terms.
   always_comb begin
      cf3_in    = PW'(cn2_ff * frac2_ff);
      cn60_3_in = NW'(cn2_ff * SIXTY);
      lm3_in    = NW'(lit2_ff * ONE_TWENTY) << FRAC_BITS;
   end

   // Stage 4: channel numerators, sector placement and power-of-two scaling.
   logic [NW-1:0] hi_n, mid_n, x_n, r_n, g_n, b_n, r_s, g_s, b_s;

   always_comb begin
      hi_n  = lm3_ff + cn60_3_ff;
      mid_n = lm3_ff - cn60_3_ff;
      x_n   = NW'({cf3_ff, 1'b0}) + mid_n;
      case (sec3_ff)
         SECT_RY: begin r_n = hi_n;  g_n = x_n;   b_n = mid_n; end
         SECT_YG: begin r_n = x_n;   g_n = hi_n;  b_n = mid_n; end
         SECT_GC: begin r_n = mid_n; g_n = hi_n;  b_n = x_n;   end
         SECT_CB: begin r_n = mid_n; g_n = x_n;   b_n = hi_n;  end
         SECT_BM: begin r_n = x_n;   g_n = mid_n; b_n = hi_n;  end
         default: begin r_n = hi_n;  g_n = mid_n; b_n = x_n;   end
      endcase
      r_s    = r_n >> SHIFT_5B;
      g_s    = g_n >> SHIFT_6B;
      b_s    = b_n >> SHIFT_5B;
      qr4_in = r_s[QW-1:0];
      qg4_in = g_s[QW-1:0];
      qb4_in = b_s[QW-1:0];
   end

   // Stage 5: divide by fifteen, clamp and pack.
   logic [QW+11:0] pr, pg, pb;
   logic [7:0]     dr, dg, db;
   logic [4:0]     red, blue;
   logic [5:0]     green;

   always_comb begin
      pr    = (QW + 12)'(qr4_ff * RECIP_15);
      pg    = (QW + 12)'(qg4_ff * RECIP_15);
      pb    = (QW + 12)'(qb4_ff * RECIP_15);
      dr    = 8'(pr >> RECIP_SH);
      dg    = 8'(pg >> RECIP_SH);
      db    = 8'(pb >> RECIP_SH);
      red   = (dr > 8'(MAX_5B)) ? MAX_5B : dr[4:0];
      green = (dg > 8'(MAX_6B)) ? MAX_6B : dg[5:0];
      blue  = (db > 8'(MAX_5B)) ? MAX_5B : db[4:0];
      pix5_in = err4_ff ? 16'd0 : {red, green, blue};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         err1_ff  <= err1_in;
         sec1_ff  <= sec1_in;
         frac1_ff <= frac1_in;
         sat1_ff  <= sat1_in;
         omd1_ff  <= omd1_in;
         lit1_ff  <= lit1_in;
      end
      if (en[2]) begin
         err2_ff  <= err1_ff;
         sec2_ff  <= sec1_ff;
         frac2_ff <= frac1_ff;
         lit2_ff  <= lit1_ff;
         cn2_ff   <= cn2_in;
      end
      if (en[3]) begin
         err3_ff   <= err2_ff;
         sec3_ff   <= sec2_ff;
         cf3_ff    <= cf3_in;
         cn60_3_ff <= cn60_3_in;
         lm3_ff    <= lm3_in;
      end
      if (en[4]) begin
         err4_ff <= err3_ff;
         qr4_ff  <= qr4_in;
         qg4_ff  <= qg4_in;
         qb4_ff  <= qb4_in;
      end
      if (en[5]) begin
         err5_ff <= err4_ff;
         pix5_ff <= pix5_in;
      end
   end

   assign rsp_valid        = vld_ff[5];
   assign rsp_pixel_rgb565 = pix5_ff;
   assign rsp_hue_error    = err5_ff;

   `CHK_IMPLY(a_err_zero, rsp_valid && rsp_hue_error, rsp_pixel_rgb565 == '0, "nonzero error pixel")
   `CHK_IMPLY(a_full_stall, !req_ready, &vld_ff, "input stalled while a stage is empty")
   `CHK_NEXT(a_s1_hold, vld_ff[1] && !en[1], $stable({sat1_ff, omd1_ff, frac1_ff}), "held word moved")

endmodule
